// File: design/bint_pkg.sv
// Shared widths and codes of the bounded integer vector.
package bint_pkg;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 11;

  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GET    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SET    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: design/bounded_int_vector.sv
// Fixed-capacity list of signed 32-bit integers with push, remove, get and set.
//
// A request is taken on a clock edge with start high and busy low. Its single result is shown
// on the out_ ports for exactly one cycle, marked by out_valid, and the receiver cannot stall
// it. Push, set and any rejected request show the result in the cycle right after the
// transfer. Get and remove show it in the first cycle after busy drops. Push, set and any
// rejected request leave busy low, so they can be issued every cycle. Get holds busy in
// state S_GET while the entry memory read completes. Remove holds busy in state S_REM and,
// while entries lie above the index, S_SHIFT: those entries move down one place per cycle
// through the single read and single write port of the entry memory. A new request is not
// taken until the get or remove is through.
module bounded_int_vector #(
  parameter int CAPACITY = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [bint_pkg::ACT_W-1:0]    in_action,
  input  logic        [bint_pkg::IDX_W-1:0]    in_index,
  input  logic signed [bint_pkg::DATA_W-1:0]   in_value,
  output logic                                 out_valid,
  output logic signed [bint_pkg::DATA_W-1:0]   out_read_value,
  output logic        [bint_pkg::ST_W-1:0]     out_status,
  output logic        [bint_pkg::LEN_W-1:0]    out_length_after
);
  import bint_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GET   = 2'd1;
  localparam logic [1:0] S_REM   = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [AW-1:0]     waddr_r, waddr_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] ord_r, ord_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic [LEN_W-1:0]  olen_r;

  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              in_rng;
  logic [AW-1:0]     idx_addr;

  assign idx_ext  = CMP_W'(in_index);
  assign cnt_ext  = CMP_W'(count_r);
  assign in_rng   = idx_ext < cnt_ext;
  assign idx_addr = idx_ext[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    waddr_nxt = waddr_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    ov_nxt    = 1'b0;
    ord_nxt   = '0;
    ost_nxt   = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_PUSH) begin
            ov_nxt = 1'b1;
            if (count_r == CNT_W'(CAPACITY)) begin
              ost_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = count_r[AW-1:0];
              mem_wd    = in_value;
              count_nxt = count_r + 1'b1;
            end
          end else if (!in_rng) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_RANGE;
          end else begin
            case (in_action)
              ACT_REMOVE: begin
                mem_re    = 1'b1;
                mem_ra    = idx_addr;
                cur_nxt   = idx_ext[CNT_W-1:0] + 1'b1;
                waddr_nxt = idx_addr;
                state_nxt = S_REM;
              end
              ACT_GET: begin
                mem_re    = 1'b1;
                mem_ra    = idx_addr;
                state_nxt = S_GET;
              end
              ACT_SET: begin
                mem_we = 1'b1;
                mem_wa = idx_addr;
                mem_wd = in_value;
                ov_nxt = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_GET: begin
        ov_nxt    = 1'b1;
        ord_nxt   = rdata_r;
        state_nxt = S_IDLE;
      end
      S_REM: begin
        res_nxt = rdata_r;
        if (cur_r < count_r) begin
          mem_re    = 1'b1;
          mem_ra    = cur_r[AW-1:0];
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          ov_nxt    = 1'b1;
          ord_nxt   = rdata_r;
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        // Each cycle writes the entry read last cycle one place lower and reads the next, if any.
        mem_we    = 1'b1;
        mem_wa    = waddr_r;
        mem_wd    = rdata_r;
        waddr_nxt = waddr_r + 1'b1;
        if (cur_r < count_r) begin
          mem_re  = 1'b1;
          mem_ra  = cur_r[AW-1:0];
          cur_nxt = cur_r + 1'b1;
        end else begin
          ov_nxt    = 1'b1;
          ord_nxt   = res_r;
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    waddr_r <= waddr_nxt;
    res_r   <= res_nxt;
    ord_r   <= ord_nxt;
    ost_r   <= ost_nxt;
    olen_r  <= LEN_W'(count_nxt);
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = ov_r;
  assign out_read_value   = ord_r;
  assign out_status       = ost_r;
  assign out_length_after = olen_r;

endmodule

// File: design/bint_chk.sv
// Port-level checker for the bounded integer vector, bound to the top level.
module bint_chk #(
  parameter int CAPACITY = 1024
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic signed [bint_pkg::DATA_W-1:0]   out_read_value,
  input logic        [bint_pkg::ST_W-1:0]     out_status,
  input logic        [bint_pkg::LEN_W-1:0]    out_length_after
);
  import bint_pkg::*;

  // A result is never shown while a get or remove request is still working.
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result transfer while busy");

  // Every accepted request either finishes at once or holds busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request produced neither result nor busy");

  // A failed request returns zero data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0))
    else $error("nonzero data on failed request");

  // A full-store rejection only happens at full capacity.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_length_after == LEN_W'(CAPACITY)))
    else $error("full status with store not full");

endmodule

bind bounded_int_vector bint_chk #(.CAPACITY(CAPACITY)) u_bint_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_read_value   (out_read_value),
  .out_status       (out_status),
  .out_length_after (out_length_after)
);
